### hw/rtl/date_validate_and_add_days_defines.svh
// Assertion helpers shared by the date block.
`ifndef DATE_VALIDATE_AND_ADD_DAYS_DEFINES_SVH
`define DATE_VALIDATE_AND_ADD_DAYS_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define DVAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define DVAD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hw/rtl/dvad_pkg.sv
package dvad_pkg;

  localparam int ADD_WIDTH = 16;
  localparam int IN_ADD_W = 16;
  localparam int CNT_W = (ADD_WIDTH < IN_ADD_W) ? ADD_WIDTH : IN_ADD_W;
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [11:0] MIN_YEAR_RESET = 12'd1001;
  localparam logic [11:0] MAX_YEAR_RESET = 12'd2021;

  localparam logic [3:0] JAN = 4'd1;
  localparam logic [3:0] FEB = 4'd2;
  localparam logic [3:0] DEC = 4'd12;

  localparam logic [8:0] DAYS_YEAR = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;

  // Multiplier for the divisibility-by-25 test on years below 8192.
  localparam logic [16:0] DIV25_MUL = 17'd5243;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] days_to_add;
  } dvad_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [12:0] out_year;
  } dvad_out_t;

  typedef struct packed {
    logic             ok;
    logic [4:0]       day;
    logic [3:0]       month;
    logic [11:0]      year;
    logic [CNT_W-1:0] add;
  } dvad_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } back_state_t;

  function automatic logic is_leap(input logic [12:0] yr);
    logic [29:0] prod;
    logic        div25;
    prod  = 30'(yr) * 30'(DIV25_MUL);
    div25 = (prod[16:0] < DIV25_MUL);
    return (yr[1:0] == 2'b00) && (!div25 || (yr[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon) inside
      FEB: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/dvad_front.sv
module dvad_front import dvad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  dvad_in_t    in_data,
  output dvad_item_t  item
);

  logic [11:0] min_year;
  logic [11:0] max_year;
  logic [4:0]  len;
  logic        ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RESET;
      max_year <= MAX_YEAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_YEAR: min_year <= cfg_data;
        CFG_MAX_YEAR: max_year <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    len = month_len(in_data.month, is_leap(13'(in_data.year)));
    ok  = (in_data.year >= min_year) && (in_data.year <= max_year) &&
          (in_data.month >= JAN) && (in_data.month <= DEC) &&
          (in_data.day != 5'd0) && (in_data.day <= len);
    item.ok    = ok;
    item.day   = in_data.day;
    item.month = in_data.month;
    item.year  = in_data.year;
    item.add   = in_data.days_to_add[CNT_W-1:0];
  end

endmodule

### hw/rtl/dvad_queue.sv
module dvad_queue import dvad_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  dvad_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output dvad_item_t pop_item
);

  dvad_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### hw/rtl/dvad_back.sv
`include "date_validate_and_add_days_defines.svh"

module dvad_back import dvad_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  dvad_item_t q_item,
  output logic       out_valid,
  input  logic       out_ready,
  output dvad_out_t  out_data
);

  back_state_t      state, state_next;
  logic             ok, ok_next;
  logic [4:0]       d, d_next;
  logic [3:0]       m, m_next;
  logic [12:0]      y, y_next;
  logic [CNT_W-1:0] add, add_next;
  logic             out_valid_next;
  dvad_out_t        out_data_next;

  logic [4:0]       cur_len;
  logic [4:0]       left;
  logic [12:0]      y_plus;
  logic             feb29;
  logic             span_leap;
  logic [8:0]       ylen;
  logic [CMP_W-1:0] add_x;
  logic [CMP_W-1:0] ylen_x;
  logic [CMP_W-1:0] left_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ok       <= ok_next;
    d        <= d_next;
    m        <= m_next;
    y        <= y_next;
    add      <= add_next;
    out_data <= out_data_next;
  end

  always_comb begin
    cur_len   = month_len(m, is_leap(y));
    left      = cur_len - d;
    y_plus    = y + 13'd1;
    feb29     = (m == FEB) && (d == 5'd29);
    span_leap = (m <= FEB) ? is_leap(y) : is_leap(y_plus);
    ylen      = span_leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
    add_x     = CMP_W'(add);
    ylen_x    = CMP_W'(ylen);
    left_x    = CMP_W'(left);

    state_next     = state;
    ok_next        = ok;
    d_next         = d;
    m_next         = m;
    y_next         = y;
    add_next       = add;
    q_pop          = 1'b0;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;

    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          ok_next    = q_item.ok;
          d_next     = q_item.day;
          m_next     = q_item.month;
          y_next     = 13'(q_item.year);
          add_next   = q_item.ok ? q_item.add : '0;
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (add == '0) begin
          state_next = BK_DONE;
        end else if (!feb29 && (add_x >= ylen_x)) begin
          y_next   = y_plus;
          add_next = CNT_W'(add_x - ylen_x);
        end else if (add_x <= left_x) begin
          d_next   = d + add_x[4:0];
          add_next = '0;
        end else begin
          add_next = CNT_W'(add_x - (left_x + CMP_W'(1)));
          d_next   = 5'd1;
          if (m == DEC) begin
            m_next = JAN;
            y_next = y_plus;
          end else begin
            m_next = m + 4'd1;
          end
        end
      end
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next          = 1'b1;
          out_data_next.valid_res = ok;
          out_data_next.out_day   = d;
          out_data_next.out_month = m;
          out_data_next.out_year  = y;
          state_next              = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  `DVAD_ASSERT(a_walk_date_ok, ((state == BK_WALK) && ok) |-> ((d != 5'd0) && (d <= cur_len)), "walk left the month")
  `DVAD_ASSERT(a_walk_progress, ((state == BK_WALK) && (add != '0)) |=> (add < $past(add)), "walk made no progress")
  `DVAD_NEVER(a_done_with_days, (state == BK_DONE) && (add != '0), "result ready with days left")
  `DVAD_NEVER(a_bad_date_walked, (state == BK_WALK) && !ok && (add != '0), "invalid date carried days")

endmodule

### hw/rtl/date_validate_and_add_days.sv
// Gregorian date check and day addition.
// Input channel in_valid/in_ready carries one word: day, month, year and a
// count of days to add. Output channel out_valid/out_ready returns one word
// per input: valid_res, and the resulting date, or the input date unchanged
// with valid_res low when the date fails the check.
// The year range is set through cfg_we/cfg_index/cfg_data: index 0 is the
// smallest accepted year, index 1 the largest. Write them only while idle.
// The front stage checks a word in the cycle it is accepted and places it in
// a two-word queue. The back stage walks the date, one step per cycle: a
// whole year when the remaining count covers it, otherwise one month, then
// the final days. The single walking unit holds one word at a time: it takes
// the next word from the queue only after the last result has gone to the
// output register.
// Reset clears the queue, the walker and the output register and restores
// the year range to 1001 through 2021.
// When the receiver stalls, the finished word holds in the output register,
// the walker waits with the next result, and the queue keeps taking input
// until it is full, after which in_ready drops.
module date_validate_and_add_days import dvad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  dvad_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output dvad_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  dvad_item_t front_item;
  dvad_item_t q_item;
  logic       q_valid;
  logic       q_pop;

  dvad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .item      (front_item)
  );

  dvad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  dvad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
